### hw/rtl/mbrot_pkg.sv
// Shared types, constants and helper functions for the escape-time pixel engine.
// No dependencies; imported by mbrot_mul and mandelbrot_escape_time.
`default_nettype none

package mbrot_pkg;

    localparam int COORD_W  = 10;
    localparam int FIX_W    = 32;
    localparam int STEP_W   = 31;
    localparam int COUNT_W  = 16;
    localparam int PROD_W   = 2 * FIX_W;
    localparam int FRAC_BITS = 28;
    localparam int CFG_ADDR_W = 3;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_REAL_START = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAG_START = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REAL_STEP  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAG_STEP  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ITER_LIMIT = 3'd4;

    // Reset values of the configuration registers.
    localparam logic signed [FIX_W-1:0] RST_REAL_START = -32'sd536870912;
    localparam logic signed [FIX_W-1:0] RST_IMAG_START = -32'sd402653184;
    localparam logic [STEP_W-1:0]       RST_REAL_STEP  = 31'd786432;
    localparam logic [STEP_W-1:0]       RST_IMAG_STEP  = 31'd786432;
    localparam logic [COUNT_W-1:0]      RST_ITER_LIMIT = 16'd256;

    // Escape threshold: 4.0 in Q4.28.
    localparam logic signed [FIX_W+1:0] ESCAPE_MAG = 34'sd1073741824;

    // Operand pair handed to the shared multiplier.
    typedef struct packed {
        logic signed [FIX_W-1:0] a;
        logic signed [FIX_W-1:0] b;
    } mul_op_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [FIX_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [FIX_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[FIX_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mbrot_mul.sv
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on mbrot_pkg for the operand struct and widths.
`default_nettype none

module mbrot_mul (
    input  wire logic                              aclk,
    input  wire mbrot_pkg::mul_op_t                op,
    output logic signed [mbrot_pkg::PROD_W-1:0]    prod
);
    import mbrot_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(op.a) * PROD_W'(op.b);

    // The product is payload only; the sequencer knows when it is valid.
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### hw/rtl/mandelbrot_escape_time.sv
// Top level of the escape-time pixel engine: sequencer, state and stream ports.
// Depends on mbrot_pkg and instantiates the shared multiplier mbrot_mul.
//
//   Channel   Direction  Handshake          Payload (lowest bit first)
//   s_        in         s_tvalid/s_tready  column[9:0], row[19:10], zero pad to 24
//   m_        out        m_tvalid/m_tready  pixel_column[9:0], pixel_row[19:10],
//                                           escape_count[35:20], zero pad to 40
//   cfg_      in         cfg_we             cfg_addr selects the register, cfg_wdata
//
// The time a word takes grows with the iterations it runs, up to the limit L,
// which is 256 after reset. It is set by the single multiplier, which forms the
// three products of each iteration one after another.
// Reset (aresetn low, synchronous) loads the register reset values, clears
// the state and empties the output register. The input side is ready only
// while the sequencer is idle; a stalled result waits in the output register
// and the next word is accepted as soon as the result has been loaded there.
`default_nettype none

module mandelbrot_escape_time (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Input word: column[9:0], row[19:10], zeros above.
    input  wire logic [mbrot_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // Result word: pixel_column[9:0], pixel_row[19:10], escape_count[35:20], zeros above.
    output logic [mbrot_pkg::M_TDATA_W-1:0]           m_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // Configuration write port.
    input  wire logic                                 cfg_we,
    input  wire logic [mbrot_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [mbrot_pkg::FIX_W-1:0]          cfg_wdata
);
    import mbrot_pkg::*;

    // Sequencer states. Each iteration runs through ITER_A to ITER_D; the
    // multiplier operands for its three products are issued in ITER_A to ITER_C.
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CRE    = 9'b000000010,
        ST_CIM    = 9'b000000100,
        ST_CI     = 9'b000001000,
        ST_ITER_A = 9'b000010000,
        ST_ITER_B = 9'b000100000,
        ST_ITER_C = 9'b001000000,
        ST_ITER_D = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic signed [FIX_W-1:0] real_start_reg, real_start_next;
    logic signed [FIX_W-1:0] imag_start_reg, imag_start_next;
    logic [STEP_W-1:0]       real_step_reg, real_step_next;
    logic [STEP_W-1:0]       imag_step_reg, imag_step_next;
    logic [COUNT_W-1:0]      limit_reg, limit_next;

    // Pixel coordinates of the word being worked on.
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;

    // Iteration state.
    logic signed [FIX_W-1:0] cr_reg, cr_next;
    logic signed [FIX_W-1:0] ci_reg, ci_next;
    logic signed [FIX_W-1:0] zr_reg, zr_next;
    logic signed [FIX_W-1:0] zi_reg, zi_next;
    logic signed [FIX_W-1:0] r2_reg, r2_next;
    logic signed [FIX_W-1:0] i2_reg, i2_next;
    logic [COUNT_W-1:0]      count_reg, count_next;

    // Output register.
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;

    // Shared multiplier.
    mul_op_t                  mul_op;
    logic signed [PROD_W-1:0] prod;

    // Datapath terms formed from the registered product.
    logic signed [PROD_W-1:0] prod_sq;
    logic signed [PROD_W-1:0] prod_cross;
    logic signed [FIX_W-1:0]  coord_re;
    logic signed [FIX_W-1:0]  coord_im;
    logic signed [FIX_W-1:0]  sq_now;
    logic signed [FIX_W+1:0]  mag;
    logic                     escaped;
    logic                     s_accept;
    logic                     out_free;

    mbrot_mul u_mul (
        .aclk (aclk),
        .op   (mul_op),
        .prod (prod)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // The arithmetic shift gives the floor of the scaled product. The cross
    // term is doubled by shifting one place less.
    assign prod_sq    = prod >>> FRAC_BITS;
    assign prod_cross = prod >>> (FRAC_BITS - 1);

    assign coord_re = sat32(PROD_W'(real_start_reg) + prod);
    assign coord_im = sat32(PROD_W'(imag_start_reg) + prod);
    assign sq_now   = sat32(prod_sq);

    // In ITER_C the real square is in r2_reg and the imaginary square is
    // just coming out of the multiplier.
    assign mag     = (FIX_W+2)'(r2_reg) + (FIX_W+2)'(sq_now);
    assign escaped = (mag >= ESCAPE_MAG);

    // Operand selection for the multiplier.
    always_comb begin
        mul_op.a = zr_reg;
        mul_op.b = zi_reg;
        case (state_reg)
            ST_CRE: begin
                mul_op.a = $signed({1'b0, real_step_reg});
                mul_op.b = $signed({{(FIX_W-COORD_W){1'b0}}, col_reg});
            end
            ST_CIM: begin
                mul_op.a = $signed({1'b0, imag_step_reg});
                mul_op.b = $signed({{(FIX_W-COORD_W){1'b0}}, row_reg});
            end
            ST_ITER_A: begin
                mul_op.a = zr_reg;
                mul_op.b = zr_reg;
            end
            ST_ITER_B: begin
                mul_op.a = zi_reg;
                mul_op.b = zi_reg;
            end
            default: begin
                mul_op.a = zr_reg;
                mul_op.b = zi_reg;
            end
        endcase
    end

    // Configuration writes; indexes past the list are ignored.
    always_comb begin
        real_start_next = real_start_reg;
        imag_start_next = imag_start_reg;
        real_step_next  = real_step_reg;
        imag_step_next  = imag_step_reg;
        limit_next      = limit_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_REAL_START: real_start_next = cfg_wdata;
                REG_IMAG_START: imag_start_next = cfg_wdata;
                REG_REAL_STEP:  real_step_next  = cfg_wdata[STEP_W-1:0];
                REG_IMAG_STEP:  imag_step_next  = cfg_wdata[STEP_W-1:0];
                REG_ITER_LIMIT: limit_next      = cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and iteration datapath.
    always_comb begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        cr_next      = cr_reg;
        ci_next      = ci_reg;
        zr_next      = zr_reg;
        zi_next      = zi_reg;
        r2_next      = r2_reg;
        i2_next      = i2_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    col_next   = s_tdata[COORD_W-1:0];
                    row_next   = s_tdata[2*COORD_W-1:COORD_W];
                    count_next = '0;
                    state_next = ST_CRE;
                end
            end
            ST_CRE: begin
                state_next = ST_CIM;
            end
            ST_CIM: begin
                // The starting point of the orbit is c itself.
                cr_next    = coord_re;
                zr_next    = coord_re;
                state_next = ST_CI;
            end
            ST_CI: begin
                ci_next    = coord_im;
                zi_next    = coord_im;
                state_next = ST_ITER_A;
            end
            ST_ITER_A: begin
                // The loop index equals the count, since an escape ends the loop.
                if (count_reg == limit_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_ITER_B;
                end
            end
            ST_ITER_B: begin
                r2_next    = sq_now;
                state_next = ST_ITER_C;
            end
            ST_ITER_C: begin
                i2_next = sq_now;
                if (escaped) begin
                    state_next = ST_DONE;
                end else begin
                    count_next = count_reg + 1'b1;
                    state_next = ST_ITER_D;
                end
            end
            ST_ITER_D: begin
                zr_next    = sat32(PROD_W'(r2_reg) - PROD_W'(i2_reg) + PROD_W'(cr_reg));
                zi_next    = sat32(PROD_W'(sat32(prod_cross)) + PROD_W'(ci_reg));
                state_next = ST_ITER_A;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(M_TDATA_W-2*COORD_W-COUNT_W){1'b0}},
                                    count_reg, row_reg, col_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            real_start_reg <= RST_REAL_START;
            imag_start_reg <= RST_IMAG_START;
            real_step_reg  <= RST_REAL_STEP;
            imag_step_reg  <= RST_IMAG_STEP;
            limit_reg      <= RST_ITER_LIMIT;
            zr_reg         <= '0;
            zi_reg         <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            real_start_reg <= real_start_next;
            imag_start_reg <= imag_start_next;
            real_step_reg  <= real_step_next;
            imag_step_reg  <= imag_step_next;
            limit_reg      <= limit_next;
            zr_reg         <= zr_next;
            zi_reg         <= zi_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        col_reg    <= col_next;
        row_reg    <= row_next;
        cr_reg     <= cr_next;
        ci_reg     <= ci_next;
        r2_reg     <= r2_next;
        i2_reg     <= i2_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // An accepted word always starts the coordinate computation.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_CRE)
        else $error("accepted word did not start the sequencer");

    // While a pixel is in flight its count never passes the limit.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (count_reg <= limit_reg))
        else $error("iteration count passed the limit");

    // A result appears only when the sequencer finishes a pixel.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word appeared without a finished pixel");
`endif

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for mandelbrot_escape_time: random and directed pixel words
// against a bit-true escape-time predictor. Needs mbrot_pkg and the engine RTL.

module tb_top;
    import mbrot_pkg::*;

    // Input word as packed on s_tdata, lowest bits first: col, row, zero pad.
    typedef struct packed {
        logic [S_TDATA_W-2*COORD_W-1:0] pad;
        logic [COORD_W-1:0]             row;
        logic [COORD_W-1:0]             col;
    } pixel_word_t;

    // Result word as packed on m_tdata, lowest bits first: col, row, count, zero pad.
    typedef struct packed {
        logic [M_TDATA_W-2*COORD_W-COUNT_W-1:0] pad;
        logic [COUNT_W-1:0]                     count;
        logic [COORD_W-1:0]                     row;
        logic [COORD_W-1:0]                     col;
    } result_word_t;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam int     ITEMS_PER_VIEW = 220;
    localparam int     RANDOM_VIEWS   = 9;
    localparam int     MAX_PRINTED    = 40;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [FIX_W-1:0]      cfg_wdata = '0;

    // Shadow copy of the view registers, as the engine should hold them.
    logic signed [FIX_W-1:0] view_real_start = RST_REAL_START;
    logic signed [FIX_W-1:0] view_imag_start = RST_IMAG_START;
    logic [STEP_W-1:0]       view_real_step  = RST_REAL_STEP;
    logic [STEP_W-1:0]       view_imag_step  = RST_IMAG_STEP;
    logic [COUNT_W-1:0]      view_limit      = RST_ITER_LIMIT;

    pixel_word_t  pixels_to_send[$];
    result_word_t expected_pixels[$];

    int     n_queued = 0;
    int     n_checked = 0;
    int     n_errors = 0;
    int     n_at_limit = 0;
    int     n_views = 0;
    int     send_gap = 0;
    int     stall_left = 0;
    bit     steady_flow = 1'b0;
    longint cycle_budget = 0;
    longint cycle_count = 0;

    pixel_word_t  taken_word;
    result_word_t predicted_word;
    result_word_t got_word;
    result_word_t want_word;

    mandelbrot_escape_time dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Clamp a wide value into the signed Q4.28 range.
    function automatic logic signed [FIX_W-1:0] clamp_q(input longint v);
        logic signed [FIX_W-1:0] r;
        if (v > Q_MAX) begin
            r = Q_MAX[FIX_W-1:0];
        end else if (v < Q_MIN) begin
            r = Q_MIN[FIX_W-1:0];
        end else begin
            r = v[FIX_W-1:0];
        end
        return r;
    endfunction

    // Escape-time count for one pixel under the current shadow view. The point c
    // is formed from start plus index times step, z starts at c, and every pass
    // with |z|^2 below four is counted before z becomes z*z + c. Products are
    // floored (arithmetic shift) and every intermediate saturates to Q4.28.
    function automatic logic [COUNT_W-1:0] escape_count_of(input logic [COORD_W-1:0] col,
                                                          input logic [COORD_W-1:0] row);
        logic signed [FIX_W-1:0] cr;
        logic signed [FIX_W-1:0] ci;
        logic signed [FIX_W-1:0] zr;
        logic signed [FIX_W-1:0] zi;
        logic signed [FIX_W-1:0] r2;
        logic signed [FIX_W-1:0] i2;
        logic signed [FIX_W-1:0] cross_term;
        logic [COUNT_W-1:0]      n;
        bit                      escaped;
        int                      k;
        cr = clamp_q(longint'(view_real_start) + longint'(view_real_step) * longint'(col));
        ci = clamp_q(longint'(view_imag_start) + longint'(view_imag_step) * longint'(row));
        zr = cr;
        zi = ci;
        n = '0;
        escaped = 1'b0;
        for (k = 0; k < int'(view_limit) && !escaped; k++) begin
            r2 = clamp_q((longint'(zr) * longint'(zr)) >>> FRAC_BITS);
            i2 = clamp_q((longint'(zi) * longint'(zi)) >>> FRAC_BITS);
            if (longint'(r2) + longint'(i2) >= longint'(ESCAPE_MAG)) begin
                escaped = 1'b1;
            end else begin
                n++;
                // The doubled cross term comes from shifting one bit less.
                cross_term = clamp_q((longint'(zr) * longint'(zi)) >>> (FRAC_BITS - 1));
                zr = clamp_q(longint'(r2) - longint'(i2) + longint'(cr));
                zi = clamp_q(longint'(cross_term) + longint'(ci));
            end
        end
        return n;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (n_errors < MAX_PRINTED) begin
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        n_errors++;
    endtask

    // One register write; the shadow follows the same masking as the hardware.
    // Indexes outside the register map must leave every register untouched.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [FIX_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_REAL_START: begin
                view_real_start = data;
            end
            REG_IMAG_START: begin
                view_imag_start = data;
            end
            REG_REAL_STEP: begin
                view_real_step = data[STEP_W-1:0];
            end
            REG_IMAG_STEP: begin
                view_imag_step = data[STEP_W-1:0];
            end
            REG_ITER_LIMIT: begin
                view_limit = data[COUNT_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic cfg_idle();
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_view(input logic [FIX_W-1:0] rs, input logic [FIX_W-1:0] is,
                             input logic [FIX_W-1:0] rstep, input logic [FIX_W-1:0] istep,
                             input logic [FIX_W-1:0] lim);
        write_reg(REG_REAL_START, rs);
        write_reg(REG_IMAG_START, is);
        write_reg(REG_REAL_STEP, rstep);
        write_reg(REG_IMAG_STEP, istep);
        write_reg(REG_ITER_LIMIT, lim);
        cfg_idle();
        n_views++;
    endtask

    // Queue one pixel and grow the timeout budget by its worst-case cost:
    // the full iteration count, plus the longest sender gap and receiver stall.
    task automatic send_pixel(input int col, input int row);
        pixel_word_t w;
        w.pad = '0;
        w.col = col[COORD_W-1:0];
        w.row = row[COORD_W-1:0];
        cycle_budget += 4 * longint'(view_limit) + 6 + 2 * 9 + 4;
        n_queued++;
        pixels_to_send.push_back(w);
    endtask

    // Block until every queued pixel has come back as a result word.
    task automatic wait_idle();
        do begin
            @(posedge aclk);
        end while (n_checked < n_queued);
    endtask

    // Driver: presents queued pixels on the input stream with random bubbles.
    // On each accepted word it runs the predictor and files the expected result,
    // since the view registers cannot change while words are in flight.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken_word           = s_tdata;
                predicted_word.pad   = '0;
                predicted_word.col   = taken_word.col;
                predicted_word.row   = taken_word.row;
                predicted_word.count = escape_count_of(taken_word.col, taken_word.row);
                expected_pixels.push_back(predicted_word);
                if (view_limit != 0 && predicted_word.count == view_limit) begin
                    n_at_limit++;
                end
            end
            // The slot is free when nothing is offered or the offer was just taken.
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pixels_to_send.size() != 0) begin
                    s_tdata  <= pixels_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    if (!steady_flow && $urandom_range(0, 4) == 0) begin
                        send_gap = $urandom_range(1, 9);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result word against the oldest expectation
    // and throttles m_tready with random stall bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_word = m_tdata;
                n_checked++;
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result word with no pixel pending, column",
                                    got_word.col, -1);
                end else begin
                    want_word = expected_pixels.pop_front();
                    if (got_word.col !== want_word.col) begin
                        report_mismatch("pixel_column", got_word.col, want_word.col);
                    end
                    if (got_word.row !== want_word.row) begin
                        report_mismatch("pixel_row", got_word.row, want_word.row);
                    end
                    if (got_word.count !== want_word.count) begin
                        report_mismatch("escape_count", got_word.count, want_word.count);
                    end
                    if (got_word.pad !== want_word.pad) begin
                        report_mismatch("tdata padding", got_word.pad, want_word.pad);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: the limit tracks the worst-case cost of everything queued so far.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 4 * cycle_budget + 20000) begin
            $display("[%0t] TIMEOUT after %0d cycles, %0d of %0d words returned",
                     $realtime, cycle_count, n_checked, n_queued);
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus: directed views first, then random views, the last one with
    // no idling on either side.
    initial begin
        int          v;
        int          n;
        int          k;
        logic [31:0] rs;
        logic [31:0] is;
        logic [31:0] rstep;
        logic [31:0] istep;
        logic [31:0] lim;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset view: corners of the image, the exact escape boundary at c = -2
        // (|z|^2 equal to four escapes at once), and two points inside the set
        // that run all the way to the reset limit.
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(0, 512);
        send_pixel(683, 512);
        send_pixel(341, 512);
        send_pixel(1023, 0);
        wait_idle();

        // Real start most negative, imaginary start most positive, largest steps,
        // limit written as zero through a value with a bit above the field: no
        // iteration may run. Step writes carry bit 31, which the 31-bit registers drop.
        load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000);
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(1023, 0);
        send_pixel(0, 1023);
        wait_idle();

        // Coordinates that saturate at the top and bottom of Q4.28, followed by
        // writes to indexes outside the register map, which must change nothing.
        load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd5);
        for (k = int'(REG_ITER_LIMIT) + 1; k < 2 ** CFG_ADDR_W; k++) begin
            write_reg(k[CFG_ADDR_W-1:0], $urandom);
        end
        cfg_idle();
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(1, 1);
        send_pixel(512, 0);
        wait_idle();

        // Largest limit, written as all ones. Column 1 lands on c = 0, which
        // never escapes; columns 2 and 3 give c = 1 and c = 2 on the real axis.
        // A zero imaginary step makes every row the same.
        load_view(32'hF000_0000, 32'h0000_0000, 32'h1000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(1, 0);
        send_pixel(2, 7);
        send_pixel(3, 1023);
        wait_idle();

        for (v = 0; v < RANDOM_VIEWS; v++) begin
            if (v == 3) begin
                // Unconstrained view: mostly saturation and immediate escape.
                rs    = $urandom;
                is    = $urandom;
                rstep = $urandom;
                istep = $urandom;
                lim   = $urandom_range(1, 64);
            end else begin
                // A window on the set: real from -2.5, imaginary from -1.5, with
                // steps that make the image span between a quarter and four units.
                rs    = $urandom_range(0, 805306368) - 32'd671088640;
                is    = $urandom_range(0, 536870912) - 32'd402653184;
                rstep = $urandom_range(65536, 1048576);
                istep = $urandom_range(65536, 1048576);
                if (v == 5) begin
                    lim = $urandom_range(200, 300);
                end else if (v == 6) begin
                    lim = $urandom_range(0, 1);
                end else begin
                    lim = $urandom_range(2, 40);
                end
            end
            if (v == RANDOM_VIEWS - 1) begin
                steady_flow = 1'b1;
            end
            load_view(rs, is, rstep, istep, lim);
            for (n = 0; n < ITEMS_PER_VIEW; n++) begin
                // Halfway through, hold the sender until the engine has drained.
                if (n == ITEMS_PER_VIEW / 2) begin
                    wait_idle();
                end
                send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
            end
            wait_idle();
        end

        // Let any stray result word show up before the final verdict.
        repeat (4 * int'(view_limit) + 40) @(posedge aclk);
        if (expected_pixels.size() != 0) begin
            report_mismatch("result words never delivered", 0, expected_pixels.size());
        end

        $display("Checked %0d result words over %0d view settings, %0d at the limit.",
                 n_checked, n_views + 1, n_at_limit);
        $display("Views included limit zero, limit 65535, saturated c and the |z|^2 = 4 edge.");
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### mandelbrot_escape_time.f
hw/rtl/mbrot_pkg.sv
hw/rtl/mbrot_mul.sv
hw/rtl/mandelbrot_escape_time.sv
test/tb_top.sv
